### rtl/rlbg_pkg.sv
// ---------------------------------------------------------------------------
// rlbg_pkg
// shared widths, register codes, thresholds and pipeline structs
// ---------------------------------------------------------------------------
package rlbg_pkg;

    localparam int MAX_LEDS   = 16;
    localparam int SPEED_W    = 16;
    localparam int CNT_W      = 5;
    localparam int LEVEL_W    = 5;
    localparam int QBITS      = 5;
    localparam int NUM_W      = SPEED_W + QBITS;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int PIPE_LAT   = 2 + (QBITS + 1) + 2;

    localparam logic [SPEED_W-1:0] REDLINE_RESET = SPEED_W'(5000);
    localparam logic [CNT_W-1:0]   LEDS_RESET    = CNT_W'(14);

    localparam logic [LEVEL_W-1:0] SPLIT_GREEN_MAX  = LEVEL_W'(4);
    localparam logic [LEVEL_W-1:0] SPLIT_BLUE_MAX   = LEVEL_W'(6);
    localparam logic [LEVEL_W-1:0] LINEAR_GREEN_MAX = LEVEL_W'(10);
    localparam logic [LEVEL_W-1:0] LINEAR_BLUE_MAX  = LEVEL_W'(13);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IDLE      = 2'd0,
        REG_REDLINE   = 2'd1,
        REG_LED_COUNT = 2'd2,
        REG_LINEAR    = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [SPEED_W-1:0] idle;
        logic [SPEED_W-1:0] redline;
        logic [CNT_W-1:0]   led_count;
        logic               linear;
    } t_cfg;

    // per-item side data that rides along the pipeline
    typedef struct packed {
        logic             phase;
        logic             lin;
        logic [CNT_W-1:0] n;
        logic [CNT_W-1:0] top;
    } t_ctl;

endpackage

### rtl/rpm_led_bar_gauge_top.sv
// ---------------------------------------------------------------------------
// rpm_led_bar_gauge_top
// engine speed to led bar level, anode mask and active-low colour rail
// ---------------------------------------------------------------------------
//
// channel   direction  handshake                     payload
// -------   ---------  ----------------------------  ---------------------------------
// item in   in         i_start & !o_busy             i_speed, i_blink_phase
// result    out        o_valid, one cycle strobe     o_bar_level, o_anode_mask, rails
// config    in         i_cfg_valid & o_cfg_ready     i_cfg_index, i_cfg_data
//
// one item accepted per cycle while o_busy is low, result strobed on o_valid at the end of the pipeline
// pipeline: two front stages, six divider stages (overflow plus one per quotient bit)
// and two output stages
// synchronous active-low reset clears all valid bits and loads register defaults
// o_busy is held high and o_cfg_ready low during reset and the first cycle after it
// the receiver cannot stall, so the pipeline never holds
//
module rpm_led_bar_gauge_top import rlbg_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // item in
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic [SPEED_W-1:0]    i_speed,
    input  logic                  i_blink_phase,
    // config write
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // result
    output logic                  o_valid,
    output logic [LEVEL_W-1:0]    o_bar_level,
    output logic [MAX_LEDS-1:0]   o_anode_mask,
    output logic                  o_red_rail,
    output logic                  o_green_rail,
    output logic                  o_blue_rail
);

    logic               r_busy;
    logic               r_cfg_ready;
    logic               w_accept;
    t_cfg               w_cfg;

    // front end to divider
    logic               w_f_valid;
    t_ctl               w_f_ctl;
    logic [NUM_W-1:0]   w_f_num;
    logic [SPEED_W-1:0] w_f_den;
    logic               w_f_zero;

    // divider to output stage
    logic               w_d_valid;
    t_ctl               w_d_ctl;
    logic [QBITS-1:0]   w_d_q;
    logic               w_d_ovf;
    logic               w_d_zero;

    // busy through reset and the first cycle after it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b1;
            r_cfg_ready <= 1'b0;
        end else begin
            r_busy      <= 1'b0;
            r_cfg_ready <= 1'b1;
        end
    end

    assign o_busy      = r_busy;
    assign o_cfg_ready = r_cfg_ready;
    assign w_accept    = i_start && !r_busy;

    rlbg_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_valid && r_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    // offset, span, scaled numerator
    rlbg_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_speed (i_speed),
        .i_phase (i_blink_phase),
        .i_cfg   (w_cfg),
        .o_valid (w_f_valid),
        .o_ctl   (w_f_ctl),
        .o_num   (w_f_num),
        .o_den   (w_f_den),
        .o_zero  (w_f_zero)
    );

    // quotient magnitude, one bit per stage
    rlbg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .i_ctl   (w_f_ctl),
        .i_num   (w_f_num),
        .i_den   (w_f_den),
        .i_zero  (w_f_zero),
        .o_valid (w_d_valid),
        .o_ctl   (w_d_ctl),
        .o_q     (w_d_q),
        .o_ovf   (w_d_ovf),
        .o_zero  (w_d_zero)
    );

    // saturation, bar pattern and colour selection
    rlbg_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_d_valid),
        .i_ctl   (w_d_ctl),
        .i_q     (w_d_q),
        .i_ovf   (w_d_ovf),
        .i_zero  (w_d_zero),
        .o_valid (o_valid),
        .o_level (o_bar_level),
        .o_mask  (o_anode_mask),
        .o_red   (o_red_rail),
        .o_green (o_green_rail),
        .o_blue  (o_blue_rail)
    );

`ifndef SYNTHESIS
    // level never beyond the led count limit
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_bar_level <= LEVEL_W'(MAX_LEDS)))
        else $error("bar level out of range");

    // exactly one colour rail is driven low
    a_one_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($countones({o_red_rail, o_green_rail, o_blue_rail}) == 2))
        else $error("colour rail select not unique");

    // empty bar lights nothing
    a_empty_bar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_bar_level == '0)) |-> (o_anode_mask == '0))
        else $error("anodes lit at level zero");

    // red only above the split green/blue bands
    a_red_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_red_rail) |-> (o_bar_level > SPLIT_BLUE_MAX))
        else $error("red rail at low level");
`endif

endmodule

### rtl/rlbg_cfg.sv
// ---------------------------------------------------------------------------
// rlbg_cfg
// configuration register file
// ---------------------------------------------------------------------------
module rlbg_cfg import rlbg_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_we,
    input  logic [CFG_IDX_W-1:0]  i_index,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.idle      <= '0;
            r_cfg.redline   <= REDLINE_RESET;
            r_cfg.led_count <= LEDS_RESET;
            r_cfg.linear    <= 1'b0;
        end else if (i_we) begin
            unique case (t_cfg_reg'(i_index))
                REG_IDLE:      r_cfg.idle      <= i_data[SPEED_W-1:0];
                REG_REDLINE:   r_cfg.redline   <= i_data[SPEED_W-1:0];
                REG_LED_COUNT: r_cfg.led_count <= i_data[CNT_W-1:0];
                REG_LINEAR:    r_cfg.linear    <= i_data[0];
                default:       r_cfg           <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/rlbg_front.sv
// ---------------------------------------------------------------------------
// rlbg_front
// span and offset, then scaled numerator magnitude and sign check
// ---------------------------------------------------------------------------
module rlbg_front import rlbg_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [SPEED_W-1:0] i_speed,
    input  logic               i_phase,
    input  t_cfg               i_cfg,
    output logic               o_valid,
    output t_ctl               o_ctl,
    output logic [NUM_W-1:0]   o_num,
    output logic [SPEED_W-1:0] o_den,
    output logic               o_zero
);

    // stage 1
    logic               r_v1;
    t_ctl               r_ctl1;
    logic [SPEED_W:0]   r_diff;
    logic [SPEED_W:0]   r_span;
    logic [CNT_W-1:0]   n_n;
    // stage 2
    logic               r_v2;
    t_ctl               r_ctl2;
    logic [NUM_W-1:0]   r_num;
    logic [SPEED_W-1:0] r_den;
    logic               r_zero;
    logic [SPEED_W:0]   n_adiff;
    logic [SPEED_W:0]   n_aspan;

    always_comb begin
        n_n = (i_cfg.led_count > CNT_W'(MAX_LEDS)) ? CNT_W'(MAX_LEDS) : i_cfg.led_count;
        n_adiff = r_diff[SPEED_W] ? (~r_diff + 1'b1) : r_diff;
        n_aspan = r_span[SPEED_W] ? (~r_span + 1'b1) : r_span;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_diff       <= {1'b0, i_speed} - {1'b0, i_cfg.idle};
        r_span       <= {1'b0, i_cfg.redline} - {1'b0, i_cfg.idle};
        r_ctl1.phase <= i_phase;
        r_ctl1.lin   <= i_cfg.linear;
        r_ctl1.n     <= n_n;
        r_ctl1.top   <= i_cfg.linear ? n_n : (n_n >> 1);

        r_ctl2 <= r_ctl1;
        r_num  <= NUM_W'(n_adiff[SPEED_W-1:0]) * NUM_W'(r_ctl1.top);
        r_den  <= n_aspan[SPEED_W-1:0];
        // opposite signs truncate to zero or below, empty span is level zero
        r_zero <= (r_diff[SPEED_W] != r_span[SPEED_W]) || (r_span == '0);
    end

    assign o_valid = r_v2;
    assign o_ctl   = r_ctl2;
    assign o_num   = r_num;
    assign o_den   = r_den;
    assign o_zero  = r_zero;

endmodule

### rtl/rlbg_div.sv
// ---------------------------------------------------------------------------
// rlbg_div
// pipelined restoring divider, overflow stage then one quotient bit a stage
// ---------------------------------------------------------------------------
module rlbg_div import rlbg_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_ctl               i_ctl,
    input  logic [NUM_W-1:0]   i_num,
    input  logic [SPEED_W-1:0] i_den,
    input  logic               i_zero,
    output logic               o_valid,
    output t_ctl               o_ctl,
    output logic [QBITS-1:0]   o_q,
    output logic               o_ovf,
    output logic               o_zero
);

    logic               r_v    [0:QBITS];
    t_ctl               r_ctl  [0:QBITS];
    logic [NUM_W-1:0]   r_rem  [0:QBITS];
    logic [SPEED_W-1:0] r_den  [0:QBITS];
    logic [QBITS-1:0]   r_q    [0:QBITS];
    logic               r_ovf  [0:QBITS];
    logic               r_zero [0:QBITS];

    // stage 0: quotient does not fit in QBITS
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ctl[0]  <= i_ctl;
        r_rem[0]  <= i_num;
        r_den[0]  <= i_den;
        r_q[0]    <= '0;
        r_ovf[0]  <= i_num >= {i_den, QBITS'(0)};
        r_zero[0] <= i_zero;
    end

    for (genvar j = 1; j <= QBITS; j++) begin : g_stage
        localparam int K = QBITS - j;
        logic [NUM_W-1:0] n_sub;
        logic             n_ge;

        assign n_sub = NUM_W'(r_den[j-1]) << K;
        assign n_ge  = r_rem[j-1] >= n_sub;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else begin
                r_v[j] <= r_v[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_ctl[j]  <= r_ctl[j-1];
            r_rem[j]  <= n_ge ? (r_rem[j-1] - n_sub) : r_rem[j-1];
            r_den[j]  <= r_den[j-1];
            r_q[j]    <= r_q[j-1] | (QBITS'(n_ge) << K);
            r_ovf[j]  <= r_ovf[j-1];
            r_zero[j] <= r_zero[j-1];
        end
    end

    assign o_valid = r_v[QBITS];
    assign o_ctl   = r_ctl[QBITS];
    assign o_q     = r_q[QBITS];
    assign o_ovf   = r_ovf[QBITS];
    assign o_zero  = r_zero[QBITS];

endmodule

### rtl/rlbg_out.sv
// ---------------------------------------------------------------------------
// rlbg_out
// level saturation, then anode mask and colour rails
// ---------------------------------------------------------------------------
module rlbg_out import rlbg_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  t_ctl                i_ctl,
    input  logic [QBITS-1:0]    i_q,
    input  logic                i_ovf,
    input  logic                i_zero,
    output logic                o_valid,
    output logic [LEVEL_W-1:0]  o_level,
    output logic [MAX_LEDS-1:0] o_mask,
    output logic                o_red,
    output logic                o_green,
    output logic                o_blue
);

    logic                r_v1;
    t_ctl                r_ctl1;
    logic [LEVEL_W-1:0]  r_lvl1;
    logic [LEVEL_W-1:0]  n_lvl;

    logic                r_v2;
    logic [LEVEL_W-1:0]  r_lvl2;
    logic [MAX_LEDS-1:0] r_mask;
    logic                r_red;
    logic                r_green;
    logic                r_blue;
    logic [MAX_LEDS-1:0] n_mask;
    logic                n_red;
    logic                n_green;
    logic                n_blue;

    always_comb begin
        if (i_zero) begin
            n_lvl = '0;
        end else if (i_ovf || (LEVEL_W'(i_q) > i_ctl.top)) begin
            n_lvl = i_ctl.top;
        end else begin
            n_lvl = LEVEL_W'(i_q);
        end
    end

    always_comb begin
        logic [CNT_W:0] idx;
        logic [CNT_W:0] lvl;
        logic [CNT_W:0] n;
        logic           lit;
        lvl    = {1'b0, r_lvl1};
        n      = {1'b0, r_ctl1.n};
        n_mask = '0;
        for (int i = 0; i < MAX_LEDS; i++) begin
            idx = (CNT_W+1)'(i);
            if (r_ctl1.lin) begin
                lit = (idx < lvl) && (r_ctl1.phase || (lvl < n));
            end else begin
                lit = ((idx < lvl) || ((n - idx) <= lvl))
                      && (r_ctl1.phase || (lvl < (n >> 1)));
            end
            n_mask[i] = lit && (idx < n);
        end
        n_red   = 1'b1;
        n_green = 1'b1;
        n_blue  = 1'b1;
        if (r_lvl1 <= (r_ctl1.lin ? LINEAR_GREEN_MAX : SPLIT_GREEN_MAX)) begin
            n_green = 1'b0;
        end else if (r_lvl1 <= (r_ctl1.lin ? LINEAR_BLUE_MAX : SPLIT_BLUE_MAX)) begin
            n_blue = 1'b0;
        end else begin
            n_red = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ctl1  <= i_ctl;
        r_lvl1  <= n_lvl;
        r_lvl2  <= r_lvl1;
        r_mask  <= n_mask;
        r_red   <= n_red;
        r_green <= n_green;
        r_blue  <= n_blue;
    end

    assign o_valid = r_v2;
    assign o_level = r_lvl2;
    assign o_mask  = r_mask;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule

### tb/sv/rpm_led_bar_gauge_top_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// rpm_led_bar_gauge_top_tb
// drives speed samples through the gauge and checks level, mask and rails
// against an in-bench model of the speed-to-bar mapping, over a range of
// idle/redline spans, led counts and both bar modes
// ---------------------------------------------------------------------------
module rpm_led_bar_gauge_top_tb import rlbg_pkg::*; ();

    // one gauge result as seen on the result ports
    typedef struct packed {
        logic [LEVEL_W-1:0]  level;
        logic [MAX_LEDS-1:0] mask;
        logic                red;
        logic                green;
        logic                blue;
    } t_gauge_out;

    // holds the expected gauge outputs in acceptance order
    class gauge_scoreboard;
        t_gauge_out expected_q[$];
        int         fail_count;

        function new();
            fail_count = 0;
        endfunction

        // speed to level, then level to colour rail and anode mask
        function t_gauge_out predict_gauge(logic [SPEED_W-1:0] spd, logic ph, t_cfg c);
            t_gauge_out r;
            int n, top, span, lvl;
            bit on;
            r.mask  = '0;
            r.red   = 1'b1;
            r.green = 1'b1;
            r.blue  = 1'b1;
            n    = (int'(c.led_count) > MAX_LEDS) ? MAX_LEDS : int'(c.led_count);
            top  = c.linear ? n : n / 2;
            span = int'(c.redline) - int'(c.idle);
            // equal idle and redline gives an empty bar, a reversed span is used as is
            if (span == 0) begin
                lvl = 0;
            end else begin
                lvl = ((int'(spd) - int'(c.idle)) * top) / span;
                if (lvl < 0) lvl = 0;
                if (lvl > top) lvl = top;
            end
            if (!c.linear) begin
                if (lvl <= int'(SPLIT_GREEN_MAX)) r.green = 1'b0;
                else if (lvl <= int'(SPLIT_BLUE_MAX)) r.blue = 1'b0;
                else r.red = 1'b0;
            end else begin
                if (lvl <= int'(LINEAR_GREEN_MAX)) r.green = 1'b0;
                else if (lvl <= int'(LINEAR_BLUE_MAX)) r.blue = 1'b0;
                else r.red = 1'b0;
            end
            for (int i = 0; i < n && i < MAX_LEDS; i++) begin
                // full bar blinks with the phase bit
                if (!c.linear)
                    on = (i < lvl || n - i <= lvl) && (ph || lvl < n / 2);
                else
                    on = (i < lvl) && (ph || lvl < n);
                if (on) r.mask[i] = 1'b1;
            end
            r.level = (lvl > 31) ? 5'd31 : LEVEL_W'(lvl);
            return r;
        endfunction

        function void note_sample(logic [SPEED_W-1:0] spd, logic ph, t_cfg c);
            expected_q.push_back(predict_gauge(spd, ph, c));
        endfunction

        function void check_result(t_gauge_out got);
            t_gauge_out exp_r;
            if (expected_q.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: level %0d mask %h r%b g%b b%b",
                             got.level, got.mask, got.red, got.green, got.blue);
                return;
            end
            exp_r = expected_q.pop_front();
            if (got.level !== exp_r.level || got.mask !== exp_r.mask ||
                got.red !== exp_r.red || got.green !== exp_r.green ||
                got.blue !== exp_r.blue) begin
                fail_count++;
                if (fail_count <= 10)
                    $display({"mismatch: exp level %0d mask %h r%b g%b b%b, ",
                              "got level %0d mask %h r%b g%b b%b"},
                             exp_r.level, exp_r.mask, exp_r.red, exp_r.green, exp_r.blue,
                             got.level, got.mask, got.red, got.green, got.blue);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_start;
    logic                  o_busy;
    logic [SPEED_W-1:0]    i_speed;
    logic                  i_blink_phase;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  o_valid;
    logic [LEVEL_W-1:0]    o_bar_level;
    logic [MAX_LEDS-1:0]   o_anode_mask;
    logic                  o_red_rail;
    logic                  o_green_rail;
    logic                  o_blue_rail;

    gauge_scoreboard sb;
    t_cfg            cfg_now;        // register values the block holds now
    int              send_idle_pct;  // chance in a hundred of an idle cycle before an item

    rpm_led_bar_gauge_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_speed       (i_speed),
        .i_blink_phase (i_blink_phase),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (o_valid),
        .o_bar_level   (o_bar_level),
        .o_anode_mask  (o_anode_mask),
        .o_red_rail    (o_red_rail),
        .o_green_rail  (o_green_rail),
        .o_blue_rail   (o_blue_rail)
    );

    // 2 ns clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #400000;
        $display("rpm_led_bar_gauge_top verification failed");
        $finish;
    end

    // sample handshakes at the edge, before the bench's own updates land
    always @(posedge i_clk) begin
        if (i_rst_n && i_start && !o_busy)
            sb.note_sample(i_speed, i_blink_phase, cfg_now);
        if (i_rst_n && o_valid)
            sb.check_result('{level: o_bar_level, mask: o_anode_mask, red: o_red_rail,
                              green: o_green_rail, blue: o_blue_rail});
    end

    // present one item, with a random idle stretch in front of it
    task automatic drive_sample(input logic [SPEED_W-1:0] spd, input logic ph);
        while ($urandom_range(99) < send_idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start       <= 1'b1;
        i_speed       <= spd;
        i_blink_phase <= ph;
        do @(posedge i_clk); while (o_busy);
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain_results();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // one register write, valid stays up for back-to-back writes
    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_IDLE:      cfg_now.idle      = data;
            REG_REDLINE:   cfg_now.redline   = data;
            REG_LED_COUNT: cfg_now.led_count = data[CNT_W-1:0];
            REG_LINEAR:    cfg_now.linear    = data[0];
            default: ;
        endcase
    endtask

    // writes all four registers; count and mode data may carry junk upper bits
    task automatic apply_config(input logic [15:0] idle, input logic [15:0] redline,
                                input logic [15:0] cnt_data, input logic [15:0] lin_data);
        write_reg(REG_IDLE, idle);
        write_reg(REG_REDLINE, redline);
        write_reg(REG_LED_COUNT, cnt_data);
        write_reg(REG_LINEAR, lin_data);
        i_cfg_valid <= 1'b0;
    endtask

    // speed mostly in and around the active span, some edges, some anything
    function automatic logic [SPEED_W-1:0] pick_speed();
        int lo, hi, margin, a, b, sel, v;
        lo     = (cfg_now.idle < cfg_now.redline) ? int'(cfg_now.idle) : int'(cfg_now.redline);
        hi     = (cfg_now.idle < cfg_now.redline) ? int'(cfg_now.redline) : int'(cfg_now.idle);
        margin = (hi - lo) / 8 + 2;
        sel    = $urandom_range(99);
        if (sel < 15) begin
            v = int'(16'($urandom));
        end else if (sel < 30) begin
            case ($urandom_range(5))
                0: v = lo;
                1: v = hi;
                2: v = lo - 1;
                3: v = lo + 1;
                4: v = hi - 1;
                default: v = hi + 1;
            endcase
        end else begin
            a = (lo - margin < 0) ? 0 : lo - margin;
            b = (hi + margin > 65535) ? 65535 : hi + margin;
            v = int'($urandom_range(b, a));
        end
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return SPEED_W'(v);
    endfunction

    // new random setting, then a run of random samples under it
    task automatic run_random_phase(input int n_items);
        logic [15:0] idle, redline, cnt_data, lin_data;
        logic [4:0]  cnt;
        int          span;
        case ($urandom_range(5))
            0: begin
                idle    = 16'($urandom);
                redline = 16'($urandom);
            end
            1: begin
                idle    = 16'($urandom_range(60000));
                span    = $urandom_range(1, 5000);
                redline = 16'(int'(idle) + span);
            end
            2: begin
                redline = 16'($urandom_range(60000));
                span    = $urandom_range(1, 5000);
                idle    = 16'(int'(redline) + span);
            end
            3: begin
                idle    = 16'($urandom);
                redline = idle;
            end
            4: begin
                idle    = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                redline = ~idle;
            end
            default: begin
                idle    = 16'd0;
                redline = REDLINE_RESET;
            end
        endcase
        // mostly legal counts, now and then zero or above the bar size
        if ($urandom_range(9) == 0) cnt = $urandom_range(1) ? 5'd0 : 5'($urandom_range(17, 31));
        else cnt = 5'($urandom_range(1, MAX_LEDS));
        cnt_data = $urandom_range(1) ? ((16'($urandom) & 16'hFFE0) | 16'(cnt)) : 16'(cnt);
        lin_data = (16'($urandom) & 16'hFFFE) | 16'($urandom_range(1));
        apply_config(idle, redline, cnt_data, lin_data);
        repeat (n_items) drive_sample(pick_speed(), 1'($urandom_range(1)));
        drain_results();
    endtask

    initial begin
        sb            = new();
        cfg_now       = '{idle: '0, redline: REDLINE_RESET, led_count: LEDS_RESET, linear: 1'b0};
        send_idle_pct = 16;
        i_rst_n       <= 1'b0;
        i_start       <= 1'b0;
        i_speed       <= '0;
        i_blink_phase <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= REG_IDLE;
        i_cfg_data    <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset setting: split bar, 14 leds, 0..5000
        drive_sample(16'd0, 1'b0);
        drive_sample(16'd5000, 1'b0);
        drive_sample(16'd5000, 1'b1);
        drive_sample(16'hFFFF, 1'b1);
        drive_sample(16'd2500, 1'b1);
        drive_sample(16'd1785, 1'b0);
        drain_results();

        // widest span, full linear bar, walk through the rail thresholds
        apply_config(16'h0000, 16'hFFFF, 16'd16, 16'd1);
        drive_sample(16'd0, 1'b1);
        drive_sample(16'hFFFF, 1'b0);
        drive_sample(16'hFFFF, 1'b1);
        drive_sample(16'd40960, 1'b1);
        drive_sample(16'd49151, 1'b0);
        drive_sample(16'd57344, 1'b1);
        drain_results();

        // redline below idle, negative span
        apply_config(16'hFFFF, 16'h0000, 16'd14, 16'd0);
        drive_sample(16'd0, 1'b1);
        drive_sample(16'hFFFF, 1'b1);
        drive_sample(16'd30000, 1'b0);
        drain_results();

        // idle equal to redline
        apply_config(16'd1000, 16'd1000, 16'd8, 16'd1);
        drive_sample(16'd1000, 1'b1);
        drive_sample(16'hFFFF, 1'b1);
        drain_results();

        // no leds at all
        apply_config(16'd0, 16'd5000, 16'd0, 16'd0);
        drive_sample(16'd5000, 1'b1);
        drain_results();

        // count above the bar size, junk in the upper data bits
        apply_config(16'd0, 16'd5000, 16'hFFFF, 16'hFFFE);
        drive_sample(16'd5000, 1'b1);
        drive_sample(16'hFFFF, 1'b0);
        drain_results();

        // odd count in split mode, middle led stays dark
        apply_config(16'd0, 16'd5000, 16'd15, 16'd0);
        drive_sample(16'd5000, 1'b1);
        drive_sample(16'd2500, 1'b1);
        drain_results();

        // single led linear bar
        apply_config(16'd0, 16'd5000, 16'd1, 16'd1);
        drive_sample(16'd5000, 1'b1);
        drive_sample(16'd0, 1'b1);
        drain_results();

        // random part: light sender gaps, heavy gaps, then back to back
        for (int regime = 0; regime < 3; regime++) begin
            send_idle_pct = (regime == 0) ? 16 : (regime == 1) ? 78 : 0;
            for (int p = 0; p < ((regime == 2) ? 3 : 4); p++)
                run_random_phase(50);
        end

        drain_results();
        // extra cycles to catch stray strobes after the last result
        repeat (3 * PIPE_LAT) @(posedge i_clk);
        if (sb.fail_count == 0 && sb.pending() == 0) begin
            $display("rpm_led_bar_gauge_top verification clean");
        end else begin
            $display("rpm_led_bar_gauge_top verification failed");
        end
        $finish;
    end

endmodule

### files.f
rtl/rlbg_pkg.sv
rtl/rlbg_cfg.sv
rtl/rlbg_front.sv
rtl/rlbg_div.sv
rtl/rlbg_out.sv
rtl/rpm_led_bar_gauge_top.sv
tb/sv/rpm_led_bar_gauge_top_tb.sv
